/* rtl/bst_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte stream tokenizer package
// Shared types, constants and character-class functions for the scanner,
// its result queue and the top level.
// ----------------------------------------------------------------------------
package bst_pkg;

   // Stream offset counter width; token offsets are reported on 16 bits
   localparam int POSITION_BITS = 16;
   localparam int FIELD_BITS    = 16;
   localparam logic [FIELD_BITS-1:0] LENGTH_MAX = {FIELD_BITS{1'b1}};

   // Result queue sizing
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // Special characters
   localparam logic [7:0] CHAR_NUL        = 8'h00;
   localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
   localparam logic [7:0] CHAR_HASH       = 8'h23;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

   // Keyword indexes into the match flags
   localparam int KW_PRINT = 0;
   localparam int KW_TRUE  = 1;
   localparam int KW_FALSE = 2;
   localparam int KW_COUNT = 3;

   typedef enum logic [2:0] {
      MODE_IDLE  = 3'd0,
      MODE_IDENT = 3'd1,
      MODE_INT   = 3'd2,
      MODE_HASH  = 3'd3,
      MODE_LINE  = 3'd4,
      MODE_BLOCK = 3'd5
   } scan_mode_type;

   typedef enum logic [3:0] {
      KIND_ILLEGAL = 4'd0,
      KIND_END     = 4'd1,
      KIND_IDENT   = 4'd2,
      KIND_INT     = 4'd3,
      KIND_ASSIGN  = 4'd4,
      KIND_PLUS    = 4'd5,
      KIND_MINUS   = 4'd6,
      KIND_STAR    = 4'd7,
      KIND_SLASH   = 4'd8,
      KIND_SEMI    = 4'd9,
      KIND_LPAREN  = 4'd10,
      KIND_RPAREN  = 4'd11,
      KIND_PRINT   = 4'd12,
      KIND_TRUE    = 4'd13,
      KIND_FALSE   = 4'd14
   } token_kind_type;

   typedef struct packed {
      token_kind_type          kind;
      logic [FIELD_BITS-1:0]   start;
      logic [FIELD_BITS-1:0]   length;
      logic                    last;
   } token_type;

   // Tokens caused by one source byte, in emission order
   typedef struct packed {
      logic [1:0] count;
      token_type  first;
      token_type  second;
   } scan_result_type;

   typedef struct packed {
      logic [QUEUE_CNT_BITS-1:0] level;
      logic                      room_for_two;
   } queue_status_type;

   function automatic logic is_alpha(input logic [7:0] b);
      return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b >= 8'h30 && b <= 8'h39;
   endfunction

   function automatic logic is_word(input logic [7:0] b);
      return is_alpha(b) || is_digit(b) || b == CHAR_UNDERSCORE;
   endfunction

   // space, tab, newline, vertical tab, form feed, carriage return
   function automatic logic is_space(input logic [7:0] b);
      return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
   endfunction

   function automatic token_kind_type op_kind(input logic [7:0] b);
      token_kind_type kind;
      case (b)
         8'h3D:   kind = KIND_ASSIGN;
         8'h2B:   kind = KIND_PLUS;
         8'h2D:   kind = KIND_MINUS;
         8'h2A:   kind = KIND_STAR;
         8'h2F:   kind = KIND_SLASH;
         8'h3B:   kind = KIND_SEMI;
         8'h28:   kind = KIND_LPAREN;
         8'h29:   kind = KIND_RPAREN;
         default: kind = KIND_ILLEGAL;
      endcase
      return kind;
   endfunction

   function automatic logic [FIELD_BITS-1:0] kw_len(input logic [1:0] k);
      logic [FIELD_BITS-1:0] n;
      case (k)
         2'd1:    n = FIELD_BITS'(4);
         default: n = FIELD_BITS'(5);
      endcase
      return n;
   endfunction

   // Keyword text: "print", "true", "false"
   function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] i);
      logic [7:0] c;
      case ({k, i})
         5'b00_000: c = 8'h70;
         5'b00_001: c = 8'h72;
         5'b00_010: c = 8'h69;
         5'b00_011: c = 8'h6E;
         5'b00_100: c = 8'h74;
         5'b01_000: c = 8'h74;
         5'b01_001: c = 8'h72;
         5'b01_010: c = 8'h75;
         5'b01_011: c = 8'h65;
         5'b10_000: c = 8'h66;
         5'b10_001: c = 8'h61;
         5'b10_010: c = 8'h6C;
         5'b10_011: c = 8'h73;
         5'b10_100: c = 8'h65;
         default:   c = CHAR_NUL;
      endcase
      return c;
   endfunction

   // Drop every keyword that the byte at offset len no longer matches
   function automatic logic [KW_COUNT-1:0] match_flags(input logic [KW_COUNT-1:0] flags,
                                                       input logic [FIELD_BITS-1:0] len,
                                                       input logic [7:0] b);
      logic [KW_COUNT-1:0] f;
      f = flags;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (len >= kw_len(2'(k)) || kw_char(2'(k), len[2:0]) != b) begin
            f[k] = 1'b0;
         end
      end
      return f;
   endfunction

   function automatic token_kind_type ident_kind(input logic [KW_COUNT-1:0] flags,
                                                 input logic [FIELD_BITS-1:0] len);
      token_kind_type kind;
      kind = KIND_IDENT;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (flags[k] && len == kw_len(2'(k))) begin
            kind = token_kind_type'(4'(int'(KIND_PRINT) + k));
         end
      end
      return kind;
   endfunction

   function automatic logic [FIELD_BITS-1:0] sat_inc(input logic [FIELD_BITS-1:0] len);
      return (len == LENGTH_MAX) ? len : len + FIELD_BITS'(1);
   endfunction

endpackage

/* rtl/bst_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte stream tokenizer scanner
// Holds the scan state and turns each accepted byte combinationally into
// zero, one or two tokens, together with the next scan state.
// ----------------------------------------------------------------------------
module bst_scan (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     byte_accept,
   input  logic [7:0]               source_byte,
   output bst_pkg::scan_result_type result
);
   import bst_pkg::*;

   scan_mode_type             mode_ff,  mode_in;
   logic [1:0]                hash_ff,  hash_in;
   logic [POSITION_BITS-1:0]  pos_ff,   pos_in;
   logic [FIELD_BITS-1:0]     start_ff, start_in;
   logic [FIELD_BITS-1:0]     len_ff,   len_in;
   logic [KW_COUNT-1:0]       flags_ff, flags_in;

   logic [31:0]               pos_wide;
   logic [FIELD_BITS-1:0]     pos16;
   logic                      fresh;
   logic                      ended;
   logic                      flush_v;
   token_type                 flush_tok;
   logic                      tail_v;
   token_type                 tail_tok;
   logic [1:0]                hash_inc;

   assign pos_wide = 32'(pos_ff);
   assign pos16    = pos_wide[FIELD_BITS-1:0];
   assign hash_inc = hash_ff + 2'd1;

   // Next scan state and tokens for the current byte
   always_comb begin
      mode_in   = mode_ff;
      hash_in   = hash_ff;
      pos_in    = pos_ff;
      start_in  = start_ff;
      len_in    = len_ff;
      flags_in  = flags_ff;
      fresh     = 1'b0;
      ended     = 1'b0;
      flush_v   = 1'b0;
      flush_tok = '{kind: KIND_IDENT, start: start_ff, length: len_ff, last: 1'b0};
      tail_v    = 1'b0;
      tail_tok  = '{kind: KIND_END, start: pos16, length: FIELD_BITS'(0), last: 1'b1};

      unique case (mode_ff)
         MODE_IDENT: begin
            if (is_word(source_byte)) begin
               flags_in = match_flags(flags_ff, len_ff, source_byte);
               len_in   = sat_inc(len_ff);
            end else begin
               flush_v        = 1'b1;
               flush_tok.kind = ident_kind(flags_ff, len_ff);
               mode_in        = MODE_IDLE;
               fresh          = 1'b1;
            end
         end
         MODE_INT: begin
            if (is_digit(source_byte)) begin
               len_in = sat_inc(len_ff);
            end else begin
               flush_v        = 1'b1;
               flush_tok.kind = KIND_INT;
               mode_in        = MODE_IDLE;
               fresh          = 1'b1;
            end
         end
         MODE_HASH: begin
            if (source_byte == CHAR_HASH) begin
               hash_in = hash_inc;
               if (hash_inc == 2'd3) begin
                  mode_in = MODE_BLOCK;
                  hash_in = 2'd0;
               end
            end else begin
               hash_in = 2'd0;
               if (source_byte == CHAR_NUL) begin
                  ended = 1'b1;
               end else if (source_byte == CHAR_NEWLINE) begin
                  mode_in = MODE_IDLE;
               end else begin
                  mode_in = MODE_LINE;
               end
            end
         end
         MODE_LINE: begin
            if (source_byte == CHAR_NUL) begin
               ended = 1'b1;
            end else if (source_byte == CHAR_NEWLINE) begin
               mode_in = MODE_IDLE;
            end
         end
         MODE_BLOCK: begin
            if (source_byte == CHAR_HASH) begin
               hash_in = hash_inc;
               if (hash_inc == 2'd3) begin
                  mode_in = MODE_IDLE;
                  hash_in = 2'd0;
               end
            end else begin
               hash_in = 2'd0;
               if (source_byte == CHAR_NUL) begin
                  ended = 1'b1;
               end
            end
         end
         default: begin
            mode_in = MODE_IDLE;
            fresh   = 1'b1;
         end
      endcase

      // Scan the byte as the start of something new
      if (fresh) begin
         if (source_byte == CHAR_NUL) begin
            ended = 1'b1;
         end else if (is_space(source_byte)) begin
            mode_in = MODE_IDLE;
         end else if (source_byte == CHAR_HASH) begin
            mode_in = MODE_HASH;
            hash_in = 2'd1;
         end else if (is_alpha(source_byte) || source_byte == CHAR_UNDERSCORE) begin
            mode_in  = MODE_IDENT;
            start_in = pos16;
            flags_in = match_flags({KW_COUNT{1'b1}}, FIELD_BITS'(0), source_byte);
            len_in   = FIELD_BITS'(1);
         end else if (is_digit(source_byte)) begin
            mode_in  = MODE_INT;
            start_in = pos16;
            len_in   = FIELD_BITS'(1);
         end else begin
            tail_v          = 1'b1;
            tail_tok.kind   = op_kind(source_byte);
            tail_tok.length = FIELD_BITS'(1);
         end
      end

      // End of stream: emit END and return to the reset state
      if (ended) begin
         tail_v   = 1'b1;
         mode_in  = MODE_IDLE;
         hash_in  = 2'd0;
         pos_in   = '0;
         start_in = '0;
         len_in   = '0;
         flags_in = {KW_COUNT{1'b1}};
      end else begin
         pos_in = pos_ff + POSITION_BITS'(1);
      end
   end

   // Order the tokens; the last one closes the run for this byte
   always_comb begin
      result.count = {1'b0, flush_v} + {1'b0, tail_v};
      if (flush_v) begin
         result.first      = flush_tok;
         result.first.last = !tail_v;
         result.second     = tail_tok;
      end else begin
         result.first  = tail_tok;
         result.second = tail_tok;
      end
   end

   // Advance the scan state on every accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         hash_ff  <= 2'd0;
         pos_ff   <= '0;
         start_ff <= '0;
         len_ff   <= '0;
         flags_ff <= {KW_COUNT{1'b1}};
      end else if (byte_accept) begin
         mode_ff  <= mode_in;
         hash_ff  <= hash_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
         len_ff   <= len_in;
         flags_ff <= flags_in;
      end
   end

endmodule

/* rtl/bst_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte stream tokenizer result queue
// Small register queue that takes up to two tokens per cycle from the
// scanner and hands them out one word per cycle while head_take is high.
// ----------------------------------------------------------------------------
module bst_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_en,
   input  bst_pkg::scan_result_type   push,
   output logic                       head_valid,
   output bst_pkg::token_type         head,
   input  logic                       head_take,
   output bst_pkg::queue_status_type  status
);
   import bst_pkg::*;

   token_type                  entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0]  level_ff,  level_in;
   logic [1:0]                 wr_count;
   logic [QUEUE_PTR_BITS-1:0]  wr_ptr_next;

   assign wr_count    = push_en ? push.count : 2'd0;
   assign wr_ptr_next = wr_ptr_ff + QUEUE_PTR_BITS'(1);

   assign head_valid          = level_ff != '0;
   assign head                = entry_ff[rd_ptr_ff];
   assign status.level        = level_ff;
   assign status.room_for_two = level_ff <= QUEUE_CNT_BITS'(QUEUE_DEPTH - 2);

   // Pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_BITS'(wr_count);
      rd_ptr_in = head_take ? rd_ptr_ff + QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      level_in  = level_ff + QUEUE_CNT_BITS'(wr_count)
                  - QUEUE_CNT_BITS'(head_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Store the incoming tokens in order
   always_ff @(posedge clock) begin
      if (wr_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (wr_count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push.second;
      end
   end

endmodule

/* rtl/byte_stream_tokenizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte stream tokenizer
// Scans a source byte stream and emits identifier, integer, keyword,
// operator, illegal and end tokens with their offsets and lengths.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one source byte per word, taken when req_valid is high and
//            req_stall is low. A 0 byte ends the stream.
//   rsp_*  : one token per word: kind, start offset, length, and
//            last_of_run set on the final token caused by a byte.
// Each byte yields zero, one or two tokens. A byte is scanned in the cycle
// it is taken and its tokens are in the result queue after that edge;
// rsp_* shows the token at the head of the queue.
// Throughput is one byte per cycle while req_stall is low; the output
// port drains one token per cycle while rsp_stall is low, so bytes that
// yield two tokens back up the four-entry queue, and req_stall rises while
// fewer than two entries are free.
// Reset clears the scan state (offset counter back to 0) and empties the
// queue. While rsp_stall is high the head token holds and the queue fills;
// END returns the scanner to its reset state so a new stream may follow.
// ----------------------------------------------------------------------------
module byte_stream_tokenizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_source_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_token_kind,
   output logic [15:0] rsp_token_start,
   output logic [15:0] rsp_token_length,
   output logic        rsp_last_of_run
);
   import bst_pkg::*;

   logic             req_accept;
   logic             rsp_take;
   scan_result_type  scan_result;
   token_type        head;
   queue_status_type queue_status;

   assign req_stall  = !queue_status.room_for_two;
   assign req_accept = req_valid && !req_stall;
   assign rsp_take   = rsp_valid && !rsp_stall;

   // Scan one byte per cycle while req_stall is low
   bst_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (req_accept),
      .source_byte (req_source_byte),
      .result      (scan_result)
   );

   // Buffer tokens toward the result port
   bst_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_en    (req_accept),
      .push       (scan_result),
      .head_valid (rsp_valid),
      .head       (head),
      .head_take  (rsp_take),
      .status     (queue_status)
   );

   assign rsp_token_kind   = head.kind;
   assign rsp_token_start  = head.start;
   assign rsp_token_length = head.length;
   assign rsp_last_of_run  = head.last;

`ifndef SYNTHESIS
   a_level_in_range: assert property (@(posedge clock) disable iff (reset)
      queue_status.level <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
      else $error("result queue level beyond depth");

   a_end_byte_gives_word: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_source_byte == CHAR_NUL |=> rsp_valid)
      else $error("end byte produced no token");

   a_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == KIND_END |-> rsp_last_of_run
      && rsp_token_length == 16'd0)
      else $error("END token not last of run or nonzero length");
`endif

endmodule
